// ===== rtl/lfk_pkg.sv =====
// ----------------------------------------------------------------------------
// Leg forward kinematics package
// Shared widths, register indexes, CORDIC constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package lfk_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned ZW          = 36;
  localparam int unsigned XW          = 34;

  localparam logic signed [ZW-1:0] Q30HalfPi    = 36'sd1686629713;
  localparam logic signed [ZW-1:0] Q30QuarterPi = 36'sd843314856;
  localparam logic signed [XW-1:0] CordicGain   = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_HIP_OFFSET = 3'd0,
    REG_THIGH      = 3'd1,
    REG_SHANK      = 3'd2,
    REG_FOOT       = 3'd3,
    REG_FOOT_ANGLE = 3'd4
  } reg_idx_e;

  // One CORDIC lane: residual angle, vector and quadrant.
  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [1:0]           k;
  } lane_t;

  localparam int unsigned NumLanes = 5;

  // Side data carried along the chain with the lanes.
  typedef struct packed {
    logic        vld;
    logic [15:0] l1;
    logic [15:0] l2;
    logic [15:0] l3;
    logic [15:0] l4;
  } side_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  atan_q30 = 36'sh03243F6A8;
      5'd1:  atan_q30 = 36'sh01DAC6705;
      5'd2:  atan_q30 = 36'sh00FADBAFC;
      5'd3:  atan_q30 = 36'sh007F56EA6;
      5'd4:  atan_q30 = 36'sh003FEAB76;
      5'd5:  atan_q30 = 36'sh001FFD55B;
      5'd6:  atan_q30 = 36'sh000FFFAAA;
      5'd7:  atan_q30 = 36'sh0007FFF55;
      5'd8:  atan_q30 = 36'sh0003FFFEA;
      5'd9:  atan_q30 = 36'sh0001FFFFD;
      5'd10: atan_q30 = 36'sh0000FFFFF;
      5'd11: atan_q30 = 36'sh00007FFFF;
      5'd12: atan_q30 = 36'sh00003FFFF;
      5'd13: atan_q30 = 36'sh00001FFFF;
      5'd14: atan_q30 = 36'sh00000FFFF;
      5'd15: atan_q30 = 36'sh000007FFF;
      5'd16: atan_q30 = 36'sh000003FFF;
      5'd17: atan_q30 = 36'sh000001FFF;
      5'd18: atan_q30 = 36'sh000000FFF;
      5'd19: atan_q30 = 36'sh0000007FF;
      5'd20: atan_q30 = 36'sh0000003FF;
      5'd21: atan_q30 = 36'sh0000001FF;
      5'd22: atan_q30 = 36'sh0000000FF;
      5'd23: atan_q30 = 36'sh00000007F;
      default: atan_q30 = '0;
    endcase
  endfunction

  // Clamp to [-65536, 65536], result 18 bits.
  function automatic logic signed [17:0] clamp_unit(input logic signed [39:0] v);
    if (v > 40'sd65536) begin
      clamp_unit = 18'sd65536;
    end else if (v < -40'sd65536) begin
      clamp_unit = -18'sd65536;
    end else begin
      clamp_unit = v[17:0];
    end
  endfunction

  // Round half up from Q.32 to Q.16 and saturate to 18 bits.
  function automatic logic signed [17:0] pos_sat(input logic signed [39:0] v);
    logic signed [39:0] r;
    r = (v + 40'sd32768) >>> 16;
    if (r > 40'sd131071) begin
      pos_sat = 18'sd131071;
    end else if (r < -40'sd131072) begin
      pos_sat = -18'sd131072;
    end else begin
      pos_sat = r[17:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lfk_cell.sv =====
// ----------------------------------------------------------------------------
// Leg forward kinematics CORDIC cell
// One rotation step for every lane, registered, handed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lfk_cell #(
  parameter int unsigned Step = 0
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  lfk_pkg::side_t                           side_i,
  input  lfk_pkg::lane_t [lfk_pkg::NumLanes-1:0]   lane_i,
  output lfk_pkg::side_t                           side_o,
  output lfk_pkg::lane_t [lfk_pkg::NumLanes-1:0]   lane_o
);

  localparam logic signed [lfk_pkg::ZW-1:0] Atan = lfk_pkg::atan_q30(5'(Step));

  lfk_pkg::lane_t [lfk_pkg::NumLanes-1:0] lane_d, lane_q;
  lfk_pkg::side_t                         side_q;

  always_comb begin
    for (int n = 0; n < lfk_pkg::NumLanes; n++) begin
      lane_d[n].k = lane_i[n].k;
      if (!lane_i[n].z[lfk_pkg::ZW-1]) begin
        lane_d[n].x = lane_i[n].x - (lane_i[n].y >>> Step);
        lane_d[n].y = lane_i[n].y + (lane_i[n].x >>> Step);
        lane_d[n].z = lane_i[n].z - Atan;
      end else begin
        lane_d[n].x = lane_i[n].x + (lane_i[n].y >>> Step);
        lane_d[n].y = lane_i[n].y - (lane_i[n].x >>> Step);
        lane_d[n].z = lane_i[n].z + Atan;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign lane_o = lane_q;
  assign side_o = side_q;

endmodule

`default_nettype wire

// ===== rtl/leg_forward_kinematics.sv =====
// ----------------------------------------------------------------------------
// Leg forward kinematics
// Foot position and orientation from hip roll, hip pitch and knee pitch.
// ----------------------------------------------------------------------------
// Pipeline: angle stage, reduction, 24 CORDIC cells and 5 math stages from
// start to done_o. Throughput: one word per cycle; busy is always low.
// Reset clears the valid chain and loads the default link registers.
// Results cannot be stalled by the receiver.
`default_nettype none

module leg_forward_kinematics (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  output logic               done_o,
  input  wire signed [17:0]  hip_roll_i,
  input  wire signed [17:0]  hip_pitch_i,
  input  wire signed [17:0]  knee_pitch_i,
  output logic signed [17:0] pos_x_o,
  output logic signed [17:0] pos_y_o,
  output logic signed [17:0] pos_z_o,
  output logic signed [17:0] rot_00_o,
  output logic signed [17:0] rot_02_o,
  output logic signed [17:0] rot_10_o,
  output logic signed [17:0] rot_11_o,
  output logic signed [17:0] rot_12_o,
  output logic signed [17:0] rot_20_o,
  output logic signed [17:0] rot_21_o,
  output logic signed [17:0] rot_22_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [4:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned N  = lfk_pkg::CordicSteps;
  localparam int unsigned ZW = lfk_pkg::ZW;
  localparam int unsigned XW = lfk_pkg::XW;

  // Configuration registers.
  logic [15:0]        l1_q, l2_q, l3_q, l4_q;
  logic signed [17:0] fa_q;
  logic               wr_en;
  logic [2:0]         reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= 16'd6554;
      l2_q <= 16'd19988;
      l3_q <= 16'd17695;
      l4_q <= 16'd2949;
      fa_q <= 18'sd25736;
    end else if (wr_en) begin
      case (reg_idx)
        lfk_pkg::REG_HIP_OFFSET: l1_q <= pwdata[15:0];
        lfk_pkg::REG_THIGH:      l2_q <= pwdata[15:0];
        lfk_pkg::REG_SHANK:      l3_q <= pwdata[15:0];
        lfk_pkg::REG_FOOT:       l4_q <= pwdata[15:0];
        lfk_pkg::REG_FOOT_ANGLE: fa_q <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lfk_pkg::REG_HIP_OFFSET: prdata = {16'd0, l1_q};
      lfk_pkg::REG_THIGH:      prdata = {16'd0, l2_q};
      lfk_pkg::REG_SHANK:      prdata = {16'd0, l3_q};
      lfk_pkg::REG_FOOT:       prdata = {16'd0, l4_q};
      lfk_pkg::REG_FOOT_ANGLE: prdata = {14'd0, fa_q};
      default:                 prdata = '0;
    endcase
  end

  // Stage 0: form the five angles in Q.30.
  logic signed [ZW-1:0] ang_q [lfk_pkg::NumLanes];
  lfk_pkg::side_t     s0_q;
  logic signed [20:0] s_sum, t_sum;

  assign s_sum = 21'(hip_pitch_i) + 21'(knee_pitch_i);
  assign t_sum = s_sum + 21'(fa_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else begin
      s0_q.vld <= start & ~busy;
      s0_q.l1  <= l1_q;
      s0_q.l2  <= l2_q;
      s0_q.l3  <= l3_q;
      s0_q.l4  <= l4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q[0] <= ZW'(hip_roll_i) <<< 15;
    ang_q[1] <= ZW'(hip_pitch_i) <<< 15;
    ang_q[2] <= ZW'(s_sum) <<< 15;
    ang_q[3] <= ZW'(t_sum) <<< 15;
    ang_q[4] <= (ZW'(s_sum) <<< 15) + lfk_pkg::Q30QuarterPi;
  end

  // Stage 1: quadrant reduction. Angles stay within about +-8 quarter turns,
  // so k is found by comparing against fixed multiples of pi/2, each less
  // pi/4, and z is what remains after the nearest multiple is taken off.
  lfk_pkg::lane_t [lfk_pkg::NumLanes-1:0] red_d;

  always_comb begin
    for (int n = 0; n < lfk_pkg::NumLanes; n++) begin
      logic signed [ZW-1:0] a, z;
      logic [1:0]           k;
      a = ang_q[n];
      k = '0;
      z = a;
      for (int m = -8; m <= 8; m++) begin
        if (a >= ZW'(m) * lfk_pkg::Q30HalfPi - lfk_pkg::Q30QuarterPi) begin
          k = 2'(m);
          z = a - ZW'(m) * lfk_pkg::Q30HalfPi;
        end
      end
      red_d[n].z = z;
      red_d[n].x = lfk_pkg::CordicGain;
      red_d[n].y = '0;
      red_d[n].k = k;
    end
  end

  lfk_pkg::lane_t [lfk_pkg::NumLanes-1:0] chain_lane [N+1];
  lfk_pkg::side_t                         chain_side [N+1];
  lfk_pkg::side_t                         s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    chain_lane[0] <= red_d;
  end

  assign chain_side[0] = s1_q;

  for (genvar g = 0; g < N; g++) begin : g_cell
    lfk_cell #(.Step(g)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .side_i (chain_side[g]),
      .lane_i (chain_lane[g]),
      .side_o (chain_side[g+1]),
      .lane_o (chain_lane[g+1])
    );
  end

  // Post stage A: round, clamp, quadrant rotate.
  logic signed [17:0] co_d [lfk_pkg::NumLanes], si_d [lfk_pkg::NumLanes];
  logic signed [17:0] co_q [lfk_pkg::NumLanes], si_q [lfk_pkg::NumLanes];
  lfk_pkg::side_t     pa_q;
  logic               pb_vld_q, pc_vld_q, pd_vld_q;

  always_comb begin
    for (int n = 0; n < lfk_pkg::NumLanes; n++) begin
      logic signed [17:0] c, s;
      c = lfk_pkg::clamp_unit(40'((chain_lane[N][n].x + XW'(8192)) >>> 14));
      s = lfk_pkg::clamp_unit(40'((chain_lane[N][n].y + XW'(8192)) >>> 14));
      case (chain_lane[N][n].k)
        2'd0: begin co_d[n] = c;  si_d[n] = s;  end
        2'd1: begin co_d[n] = -s; si_d[n] = c;  end
        2'd2: begin co_d[n] = -c; si_d[n] = -s; end
        default: begin co_d[n] = s; si_d[n] = -c; end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q     <= '0;
      pb_vld_q <= 1'b0;
      pc_vld_q <= 1'b0;
      pd_vld_q <= 1'b0;
      done_o   <= 1'b0;
    end else begin
      pa_q     <= chain_side[N];
      pb_vld_q <= pa_q.vld;
      pc_vld_q <= pb_vld_q;
      pd_vld_q <= pc_vld_q;
      done_o   <= pd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    co_q <= co_d;
    si_q <= si_d;
  end

  // Post stage B: link products and orientation products.
  logic signed [39:0] px_q, a_q;
  logic signed [39:0] l1c_q, l1s_q;
  logic signed [17:0] cr_b, sr_b;
  logic signed [17:0] r00_b, r02_b, r10_b, r11_b, r12_b, r20_b, r21_b, r22_b;

  always_ff @(posedge clk_i) begin
    px_q  <= -(40'($signed({1'b0, pa_q.l2})) * 40'(si_q[1])
             + 40'($signed({1'b0, pa_q.l3})) * 40'(si_q[2])
             + 40'($signed({1'b0, pa_q.l4})) * 40'(si_q[3]));
    a_q   <= 40'($signed({1'b0, pa_q.l2})) * 40'(co_q[1])
             + 40'($signed({1'b0, pa_q.l3})) * 40'(co_q[2])
             + 40'($signed({1'b0, pa_q.l4})) * 40'(co_q[3]);
    l1c_q <= 40'($signed({1'b0, pa_q.l1})) * 40'(co_q[0]);
    l1s_q <= 40'($signed({1'b0, pa_q.l1})) * 40'(si_q[0]);
    cr_b  <= co_q[0];
    sr_b  <= si_q[0];
    r00_b <= lfk_pkg::clamp_unit(40'(co_q[4]));
    r02_b <= lfk_pkg::clamp_unit(-40'(si_q[4]));
    r11_b <= lfk_pkg::clamp_unit(-40'(co_q[0]));
    r21_b <= lfk_pkg::clamp_unit(-40'(si_q[0]));
    r10_b <= lfk_pkg::clamp_unit((40'(si_q[0]) * 40'(si_q[4]) + 40'sd32768) >>> 16);
    r12_b <= lfk_pkg::clamp_unit((40'(si_q[0]) * 40'(co_q[4]) + 40'sd32768) >>> 16);
    r20_b <= lfk_pkg::clamp_unit((-40'(co_q[0]) * 40'(si_q[4]) + 40'sd32768) >>> 16);
    r22_b <= lfk_pkg::clamp_unit((-40'(co_q[0]) * 40'(co_q[4]) + 40'sd32768) >>> 16);
  end

  // Post stage C: round A to Q.16.
  logic signed [23:0] a16_q;
  logic signed [39:0] px_c, l1c_c, l1s_c;
  logic signed [17:0] cr_c, sr_c;
  logic signed [17:0] r00_c, r02_c, r10_c, r11_c, r12_c, r20_c, r21_c, r22_c;

  always_ff @(posedge clk_i) begin
    a16_q <= 24'((a_q + 40'sd32768) >>> 16);
    px_c  <= px_q;
    l1c_c <= l1c_q;
    l1s_c <= l1s_q;
    cr_c  <= cr_b;
    sr_c  <= sr_b;
    {r00_c, r02_c, r10_c, r11_c} <= {r00_b, r02_b, r10_b, r11_b};
    {r12_c, r20_c, r21_c, r22_c} <= {r12_b, r20_b, r21_b, r22_b};
  end

  // Post stage D: second products.
  logic signed [39:0] py_d, pz_d, px_d;
  logic signed [17:0] r00_d, r02_d, r10_d, r11_d, r12_d, r20_d, r21_d, r22_d;

  always_ff @(posedge clk_i) begin
    py_d <= l1c_c + 40'(a16_q) * 40'(sr_c);
    pz_d <= l1s_c - 40'(a16_q) * 40'(cr_c);
    px_d <= px_c;
    {r00_d, r02_d, r10_d, r11_d} <= {r00_c, r02_c, r10_c, r11_c};
    {r12_d, r20_d, r21_d, r22_d} <= {r12_c, r20_c, r21_c, r22_c};
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    pos_x_o  <= lfk_pkg::pos_sat(px_d);
    pos_y_o  <= lfk_pkg::pos_sat(py_d);
    pos_z_o  <= lfk_pkg::pos_sat(pz_d);
    rot_00_o <= r00_d;
    rot_02_o <= r02_d;
    rot_10_o <= r10_d;
    rot_11_o <= r11_d;
    rot_12_o <= r12_d;
    rot_20_o <= r20_d;
    rot_21_o <= r21_d;
    rot_22_o <= r22_d;
  end

endmodule

`default_nettype wire

// ===== test/leg_forward_kinematics_test.sv =====
// ----------------------------------------------------------------------------
// Leg forward kinematics testbench
// Drives joint-angle words through the pipeline, predicts foot position and
// orientation with a bit-exact CORDIC model, and checks every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module leg_forward_kinematics_test;

  typedef struct packed {
    logic signed [17:0] roll;
    logic signed [17:0] pitch;
    logic signed [17:0] knee;
  } joints_t;

  typedef struct packed {
    logic signed [17:0] px, py, pz;
    logic signed [17:0] r00, r02, r10, r11, r12, r20, r21, r22;
  } pose_t;

  localparam longint HalfPi    = 64'sd1686629713;
  localparam longint QuarterPi = 64'sd843314856;
  localparam longint Gain      = 64'sd652032874;
  localparam int     WatchLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy, done_o, pready;
  logic signed [17:0] hip_roll_i = '0, hip_pitch_i = '0, knee_pitch_i = '0;
  logic signed [17:0] pos_x_o, pos_y_o, pos_z_o;
  logic signed [17:0] rot_00_o, rot_02_o, rot_10_o, rot_11_o, rot_12_o;
  logic signed [17:0] rot_20_o, rot_21_o, rot_22_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;

  // Link configuration as the block should currently hold it.
  longint link_hip, link_thigh, link_shank, link_foot, ankle_angle;

  joints_t pending_words[$];
  pose_t   expected_poses[$];
  int      fail_count = 0;
  int      idle_cycles = 0;
  int      gap_left = 0;
  int      burst_left = 0;
  bit      drive_enable = 1'b0;
  bit      hold_off = 1'b0;

  leg_forward_kinematics u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint floor_shift(longint v, int sh);
    if (v >= 0) return v >>> sh;
    return -((-(v + 1)) >>> sh) - 1;
  endfunction

  function automatic longint round_half_up(longint v, int sh);
    return floor_shift(v + (64'sd1 <<< (sh - 1)), sh);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl[24] = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA,
      64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF,
      64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF,
      64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return tbl[i];
  endfunction

  // Cosine and sine in Q1.16 of an angle in Q.30 radians.
  function automatic void sin_cos(input longint ang, output longint co,
                                  output longint si);
    longint base, quad, z, x, y, dx, dy, c, s;
    base = ang + 16 * HalfPi;
    quad = (base + QuarterPi) / HalfPi;
    z = base - quad * HalfPi;
    x = Gain;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = clip(round_half_up(x, 14), -65536, 65536);
    s = clip(round_half_up(y, 14), -65536, 65536);
    case (quad & 3)
      0: begin co = c; si = s; end
      1: begin co = -s; si = c; end
      2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  function automatic logic signed [17:0] to_position(longint q32);
    return 18'(clip(round_half_up(q32, 16), -131072, 131071));
  endfunction

  function automatic logic signed [17:0] to_unit(longint q16);
    return 18'(clip(q16, -65536, 65536));
  endfunction

  function automatic void predict_pose(input joints_t j, output pose_t p);
    longint r, ph, sum, tip, cr, sr, cp, sp, cs, ss, ct, st, cu, su, a16;
    r = j.roll;
    ph = j.pitch;
    sum = ph + longint'(j.knee);
    tip = sum + ankle_angle;
    sin_cos(r * 32768, cr, sr);
    sin_cos(ph * 32768, cp, sp);
    sin_cos(sum * 32768, cs, ss);
    sin_cos(tip * 32768, ct, st);
    sin_cos(sum * 32768 + QuarterPi, cu, su);
    a16 = round_half_up(link_thigh * cp + link_shank * cs + link_foot * ct, 16);
    p.px  = to_position(-(link_thigh * sp + link_shank * ss + link_foot * st));
    p.py  = to_position(link_hip * cr + a16 * sr);
    p.pz  = to_position(-(a16 * cr) + link_hip * sr);
    p.r00 = to_unit(cu);
    p.r02 = to_unit(-su);
    p.r10 = to_unit(round_half_up(sr * su, 16));
    p.r11 = to_unit(-cr);
    p.r12 = to_unit(round_half_up(sr * cu, 16));
    p.r20 = to_unit(round_half_up(-cr * su, 16));
    p.r21 = to_unit(-sr);
    p.r22 = to_unit(round_half_up(-cr * cu, 16));
  endfunction

  function automatic pose_t predict_pose_word(joints_t j);
    pose_t p;
    predict_pose(j, p);
    return p;
  endfunction

  task automatic write_register(input lfk_pkg::reg_idx_e idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 5'(idx) << 2; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      lfk_pkg::REG_HIP_OFFSET: link_hip = longint'(value[15:0]);
      lfk_pkg::REG_THIGH:      link_thigh = longint'(value[15:0]);
      lfk_pkg::REG_SHANK:      link_shank = longint'(value[15:0]);
      lfk_pkg::REG_FOOT:       link_foot = longint'(value[15:0]);
      lfk_pkg::REG_FOOT_ANGLE: ankle_angle = longint'($signed(value[17:0]));
      default: ;
    endcase
  endtask

  function automatic logic signed [17:0] random_angle();
    case ($urandom_range(0, 5))
      0: return 18'sh1FFFF;
      1: return 18'sh20000;
      2: return 18'(longint'($urandom_range(0, 4000)) - 2000);
      default: return 18'($urandom);
    endcase
  endfunction

  task automatic queue_word(input int a, b, c);
    pending_words.push_back('{roll: 18'(a), pitch: 18'(b), knee: 18'(c)});
  endtask

  // Waits until the pipeline has drained before a register is touched.
  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_poses.size() != 0)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_links(input logic [15:0] a, b, c, d, input logic [17:0] e);
    wait_drained();
    drive_enable = 1'b0;
    write_register(lfk_pkg::REG_HIP_OFFSET, 32'(a));
    write_register(lfk_pkg::REG_THIGH, 32'(b));
    write_register(lfk_pkg::REG_SHANK, 32'(c));
    write_register(lfk_pkg::REG_FOOT, 32'(d));
    write_register(lfk_pkg::REG_FOOT_ANGLE, 32'(e));
    drive_enable = 1'b1;
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++)
      queue_word(int'(random_angle()), int'(random_angle()), int'(random_angle()));
  endtask

  task automatic launch_next();
    if (gap_left > 0) begin
      gap_left--;
      start <= 1'b0;
    end else if (pending_words.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      start <= 1'b1;
      hip_roll_i <= pending_words[0].roll;
      hip_pitch_i <= pending_words[0].pitch;
      knee_pitch_i <= pending_words[0].knee;
    end else begin
      start <= 1'b0;
    end
  endtask

  task automatic check_field(string name, logic signed [17:0] exp_v, act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Sender: bursts with random gaps, fed from the pending queue.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_poses.push_back(predict_pose_word(pending_words.pop_front()));
      if (drive_enable && !hold_off) launch_next();
      else start <= 1'b0;
    end else if (!drive_enable || hold_off) begin
      start <= 1'b0;
    end else if (!start) begin
      launch_next();
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk_i) begin
    pose_t e;
    if (rst_ni) begin
      if ((start && !busy) || done_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (done_o) begin
        if (expected_poses.size() == 0) begin
          $error("result word with no expectation pending");
          fail_count++;
        end else begin
          e = expected_poses.pop_front();
          check_field("pos_x", e.px, pos_x_o);
          check_field("pos_y", e.py, pos_y_o);
          check_field("pos_z", e.pz, pos_z_o);
          check_field("rot_00", e.r00, rot_00_o);
          check_field("rot_02", e.r02, rot_02_o);
          check_field("rot_10", e.r10, rot_10_o);
          check_field("rot_11", e.r11, rot_11_o);
          check_field("rot_12", e.r12, rot_12_o);
          check_field("rot_20", e.r20, rot_20_o);
          check_field("rot_21", e.r21, rot_21_o);
          check_field("rot_22", e.r22, rot_22_o);
        end
      end
      if (idle_cycles >= WatchLimit) begin
        $display("leg_forward_kinematics_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    link_hip = 6554; link_thigh = 19988; link_shank = 17695;
    link_foot = 2949; ankle_angle = 25736;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    drive_enable = 1'b1;

    // Directed words at reset settings: zero, extremes, quadrant edges.
    queue_word(0, 0, 0);
    queue_word(131071, 131071, 131071);
    queue_word(-131072, -131072, -131072);
    queue_word(131071, -131072, 131071);
    queue_word(51472, -51472, 51472);
    queue_word(25736, 25736, -25736);
    queue_word(-25736, 102944, 102944);
    queue_word(87381, -87382, 0);
    queue_word(1, -1, 1);
    queue_word(77208, -77208, 0);
    random_phase(300);

    // Long links drive the position into saturation.
    load_links(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 18'h1FFFF);
    queue_word(0, 0, 0);
    queue_word(0, 51472, 51472);
    queue_word(51472, 0, 0);
    random_phase(300);

    load_links(16'h0000, 16'h0000, 16'h0000, 16'h0000, 18'h20000);
    random_phase(150);

    // After the pipeline has emptied, the sender is held off and then released.
    wait_drained();
    hold_off = 1'b1;
    repeat (5) @(posedge clk_i);
    hold_off = 1'b0;

    load_links(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               18'($urandom));
    random_phase(400);
    load_links(16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF, 18'h15555);
    random_phase(370);

    wait_drained();
    if (fail_count == 0) begin
      $display("leg_forward_kinematics_test OK");
    end else begin
      $display("leg_forward_kinematics_test NOT OK");
    end
    $finish;
  end

endmodule
